>>> hw/rtl/rlpd_pkg.sv
package rlpd_pkg;

  // widest length field accepted, in bytes (1..8)
  localparam int LEN_BYTES = 4;
  localparam int CNT_W     = 8 * LEN_BYTES;
  localparam int LBL_W     = $clog2(LEN_BYTES + 1);

  localparam logic [7:0] SINGLE_MAX    = 8'h7f;
  localparam logic [7:0] STR_BASE      = 8'h80;
  localparam logic [7:0] STR_SHORT_MAX = 8'hb7;
  localparam logic [7:0] STR_LONG_MAX  = 8'hbf;
  localparam logic [7:0] LIST_BASE     = 8'hc0;
  localparam logic [7:0] LIST_SHORT_MAX = 8'hf7;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_LLEN,
    PH_ITEM,
    PH_SLEN,
    PH_PAY,
    PH_DROP
  } phase_t;

  typedef enum logic [1:0] {
    K_PAYLOAD = 2'd0,
    K_EMPTY   = 2'd1,
    K_MSGEND  = 2'd2,
    K_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NOT_LIST = 3'd1,
    ERR_TRUNC    = 3'd2,
    ERR_NESTED   = 3'd3,
    ERR_OVERRUN  = 3'd4,
    ERR_WIDE     = 3'd5
  } err_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       item_start;
    logic       item_end;
    logic       msg_end;
    err_t       err_code;
  } res_t;

endpackage

>>> hw/rtl/rlp_flat_list_decoder.sv
// Streaming decoder for one RLP message that is a single flat list of strings.
// Bytes enter one per cycle on the in_ channel, with in_last on the final byte;
// each byte yields zero or one transaction on the out_ channel: a payload byte
// with item start/end marks, an empty item, a bare message end, or an error
// code, after which the rest of the message is dropped up to in_last. While the
// output is not stalled, the block sustains one byte per cycle: each byte sits
// in an input register, is decoded against the parse counters combinationally
// and lands in the output register, so a result passes both registers before
// it is on out_. A stalled output holds both registers and stalls the input.
// Length fields up to LEN_BYTES bytes (package constant) are accepted.
module rlp_flat_list_decoder
  import rlpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_data,
  output logic       out_item_start,
  output logic       out_item_end,
  output logic       out_msg_end,
  output logic [2:0] out_err_code
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r;
  res_t       out_res_r;
  logic       advance;
  logic       in_take;
  logic       res_valid;
  res_t       res;

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
  end

  rlpd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_valid_r && advance),
    .byte_in   (s1_byte_r),
    .last_in   (s1_last_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_res_r.kind;
  assign out_data       = out_res_r.data;
  assign out_item_start = out_res_r.item_start;
  assign out_item_end   = out_res_r.item_end;
  assign out_msg_end    = out_res_r.msg_end;
  assign out_err_code   = out_res_r.err_code;

endmodule

>>> hw/rtl/rlpd_decode.sv
module rlpd_decode
  import rlpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_in,
  input  logic       last_in,
  output logic       res_valid,
  output res_t       res
);

  phase_t             phase_r, phase_nxt;
  logic [LBL_W-1:0]   lbl_r, lbl_nxt;
  logic [CNT_W-1:0]   accum_r, accum_nxt;
  logic [CNT_W-1:0]   pay_left_r, pay_left_nxt;
  logic [CNT_W-1:0]   declared_r, declared_nxt;
  logic [CNT_W-1:0]   seen_r, seen_nxt;
  logic               pay_first_r, pay_first_nxt;

  logic [CNT_W-1:0]   accum_shift;
  logic [LBL_W-1:0]   lbl_dec;
  logic               len_done;
  logic [CNT_W-1:0]   seen_inc;
  logic [CNT_W-1:0]   pay_dec;
  logic               pay_end;
  logic [7:0]         list_n;
  logic [7:0]         str_n;
  logic               fail;
  err_t               err;

  assign accum_shift = (accum_r << 8) | CNT_W'(byte_in);
  assign lbl_dec     = (lbl_r != '0) ? lbl_r - LBL_W'(1) : lbl_r;
  assign len_done    = (lbl_dec == '0);
  assign seen_inc    = (seen_r == '1) ? seen_r : seen_r + CNT_W'(1);
  assign pay_dec     = (pay_left_r != '0) ? pay_left_r - CNT_W'(1) : pay_left_r;
  assign pay_end     = (pay_dec == '0);
  assign list_n      = byte_in - LIST_SHORT_MAX;
  assign str_n       = byte_in - STR_SHORT_MAX;

  // result of the current byte
  always_comb begin
    res_valid      = 1'b0;
    res            = '0;
    res.kind       = K_PAYLOAD;
    res.err_code   = ERR_NONE;
    res.msg_end    = last_in;
    fail           = 1'b0;
    err            = ERR_NONE;
    case (phase_r)
      PH_HDR: begin
        if (byte_in < LIST_BASE) begin
          fail = 1'b1;
          err  = ERR_NOT_LIST;
        end else if (byte_in <= LIST_SHORT_MAX) begin
          if (last_in) begin
            res_valid = 1'b1;
            res.kind  = K_MSGEND;
            if (byte_in != LIST_BASE) begin
              fail = 1'b1;
              err  = ERR_OVERRUN;
            end
          end
        end else if (list_n > 8'(LEN_BYTES)) begin
          fail = 1'b1;
          err  = ERR_WIDE;
        end else if (last_in) begin
          fail = 1'b1;
          err  = ERR_TRUNC;
        end
      end
      PH_LLEN: begin
        if (len_done) begin
          if (last_in) begin
            res_valid = 1'b1;
            res.kind  = K_MSGEND;
            if (accum_shift != '0) begin
              fail = 1'b1;
              err  = ERR_OVERRUN;
            end
          end
        end else if (last_in) begin
          fail = 1'b1;
          err  = ERR_TRUNC;
        end
      end
      PH_ITEM, PH_SLEN, PH_PAY: begin
        if (last_in && (declared_r > seen_inc)) begin
          fail = 1'b1;
          err  = ERR_OVERRUN;
        end else if (phase_r == PH_ITEM) begin
          if (byte_in <= SINGLE_MAX) begin
            res_valid      = 1'b1;
            res.data       = byte_in;
            res.item_start = 1'b1;
            res.item_end   = 1'b1;
          end else if (byte_in == STR_BASE) begin
            res_valid = 1'b1;
            res.kind  = K_EMPTY;
          end else if (byte_in <= STR_SHORT_MAX) begin
            if (last_in) begin
              fail = 1'b1;
              err  = ERR_TRUNC;
            end
          end else if (byte_in <= STR_LONG_MAX) begin
            if (str_n > 8'(LEN_BYTES)) begin
              fail = 1'b1;
              err  = ERR_WIDE;
            end else if (last_in) begin
              fail = 1'b1;
              err  = ERR_TRUNC;
            end
          end else begin
            fail = 1'b1;
            err  = ERR_NESTED;
          end
        end else if (phase_r == PH_SLEN) begin
          if (len_done && (accum_shift == '0)) begin
            res_valid = 1'b1;
            res.kind  = K_EMPTY;
          end else if (last_in) begin
            fail = 1'b1;
            err  = ERR_TRUNC;
          end
        end else begin
          if (last_in && !pay_end) begin
            fail = 1'b1;
            err  = ERR_TRUNC;
          end else begin
            res_valid      = 1'b1;
            res.data       = byte_in;
            res.item_start = pay_first_r;
            res.item_end   = pay_end;
          end
        end
      end
      default: begin
      end
    endcase
    if (fail) begin
      res_valid      = 1'b1;
      res.kind       = K_ERROR;
      res.data       = '0;
      res.item_start = 1'b0;
      res.item_end   = 1'b0;
      res.err_code   = err;
    end
  end

  // next state; every last byte rearms the header phase
  always_comb begin
    phase_nxt     = phase_r;
    lbl_nxt       = lbl_r;
    accum_nxt     = accum_r;
    pay_left_nxt  = pay_left_r;
    declared_nxt  = declared_r;
    seen_nxt      = seen_r;
    pay_first_nxt = pay_first_r;
    case (phase_r)
      PH_HDR: begin
        seen_nxt  = '0;
        accum_nxt = '0;
        if (byte_in <= LIST_SHORT_MAX) begin
          declared_nxt = CNT_W'(byte_in - LIST_BASE);
          phase_nxt    = PH_ITEM;
        end else begin
          declared_nxt = '0;
          lbl_nxt      = LBL_W'(list_n);
          phase_nxt    = PH_LLEN;
        end
      end
      PH_LLEN: begin
        accum_nxt = accum_shift;
        lbl_nxt   = lbl_dec;
        if (len_done) begin
          declared_nxt = accum_shift;
          seen_nxt     = '0;
          phase_nxt    = PH_ITEM;
        end
      end
      PH_ITEM: begin
        seen_nxt = seen_inc;
        if (byte_in inside {[STR_BASE + 8'd1 : STR_SHORT_MAX]}) begin
          pay_left_nxt  = CNT_W'(byte_in - STR_BASE);
          pay_first_nxt = 1'b1;
          phase_nxt     = PH_PAY;
        end else if (byte_in inside {[STR_SHORT_MAX + 8'd1 : STR_LONG_MAX]}) begin
          lbl_nxt   = LBL_W'(str_n);
          accum_nxt = '0;
          phase_nxt = PH_SLEN;
        end
      end
      PH_SLEN: begin
        seen_nxt  = seen_inc;
        accum_nxt = accum_shift;
        lbl_nxt   = lbl_dec;
        if (len_done) begin
          if (accum_shift == '0) begin
            phase_nxt = PH_ITEM;
          end else begin
            pay_left_nxt  = accum_shift;
            pay_first_nxt = 1'b1;
            phase_nxt     = PH_PAY;
          end
        end
      end
      PH_PAY: begin
        seen_nxt      = seen_inc;
        pay_left_nxt  = pay_dec;
        pay_first_nxt = 1'b0;
        if (pay_end) begin
          phase_nxt = PH_ITEM;
        end
      end
      default: begin
      end
    endcase
    if (fail) begin
      phase_nxt = PH_DROP;
    end
    if (last_in) begin
      phase_nxt = PH_HDR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HDR;
      lbl_r       <= '0;
      accum_r     <= '0;
      pay_left_r  <= '0;
      declared_r  <= '0;
      seen_r      <= '0;
      pay_first_r <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      lbl_r       <= lbl_nxt;
      accum_r     <= accum_nxt;
      pay_left_r  <= pay_left_nxt;
      declared_r  <= declared_nxt;
      seen_r      <= seen_nxt;
      pay_first_r <= pay_first_nxt;
    end
  end

endmodule

>>> dv/rlpd_stream_check.sv
`timescale 1ns / 100ps
module rlpd_stream_check
  import rlpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [1:0] out_kind,
  input  logic [7:0] out_data,
  input  logic       out_item_start,
  input  logic       out_item_end,
  input  logic       out_msg_end,
  input  logic [2:0] out_err_code,
  output int         mismatch_cnt,
  output int         outstanding
);

  // parse state mirrored from the byte stream
  phase_t           st_phase;
  int unsigned      st_len_left;
  logic [CNT_W-1:0] st_accum;
  logic [CNT_W-1:0] st_pay_left;
  logic [CNT_W-1:0] st_declared;
  logic [CNT_W-1:0] st_seen;
  logic             st_first;

  res_t decoded_q[$];

  function automatic void queue_result(input res_t r);
    decoded_q = {decoded_q, r};
  endfunction

  function automatic bit raise_err(input err_t code, input logic last, output res_t r);
    st_phase     = last ? PH_HDR : PH_DROP;
    r.kind       = K_ERROR;
    r.data       = 8'h00;
    r.item_start = 1'b0;
    r.item_end   = 1'b0;
    r.msg_end    = last;
    r.err_code   = code;
    return 1'b1;
  endfunction

  // last byte with nothing of its own to report: bare end, or overrun
  function automatic bit close_msg(output res_t r);
    st_phase     = PH_HDR;
    r.kind       = (st_declared > st_seen) ? K_ERROR : K_MSGEND;
    r.err_code   = (st_declared > st_seen) ? ERR_OVERRUN : ERR_NONE;
    r.data       = 8'h00;
    r.item_start = 1'b0;
    r.item_end   = 1'b0;
    r.msg_end    = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic last, output res_t r);
    int unsigned n;
    r.kind       = K_PAYLOAD;
    r.data       = 8'h00;
    r.item_start = 1'b0;
    r.item_end   = 1'b0;
    r.msg_end    = last;
    r.err_code   = ERR_NONE;
    case (st_phase)
      PH_HDR: begin
        if (b < LIST_BASE) return raise_err(ERR_NOT_LIST, last, r);
        st_seen  = '0;
        st_accum = '0;
        if (b <= LIST_SHORT_MAX) begin
          st_declared = CNT_W'(b - LIST_BASE);
          st_phase    = PH_ITEM;
          if (last) return close_msg(r);
          return 1'b0;
        end
        n = 32'(b - LIST_SHORT_MAX);
        if (n > LEN_BYTES) return raise_err(ERR_WIDE, last, r);
        st_declared = '0;
        st_len_left = n;
        st_phase    = PH_LLEN;
        if (last) return raise_err(ERR_TRUNC, last, r);
        return 1'b0;
      end
      PH_LLEN: begin
        st_accum = (st_accum << 8) | CNT_W'(b);
        if (st_len_left > 0) st_len_left--;
        if (st_len_left == 0) begin
          st_declared = st_accum;
          st_seen     = '0;
          st_phase    = PH_ITEM;
          if (last) return close_msg(r);
          return 1'b0;
        end
        if (last) return raise_err(ERR_TRUNC, last, r);
        return 1'b0;
      end
      PH_ITEM, PH_SLEN, PH_PAY: begin
        if (st_seen != '1) st_seen++;
        // overrun takes priority over anything the byte itself would give
        if (last && st_declared > st_seen) return raise_err(ERR_OVERRUN, last, r);
      end
      default: begin
        if (last) st_phase = PH_HDR;
        return 1'b0;
      end
    endcase

    if (st_phase == PH_ITEM) begin
      if (b <= SINGLE_MAX) begin
        if (last) st_phase = PH_HDR;
        r.data       = b;
        r.item_start = 1'b1;
        r.item_end   = 1'b1;
        return 1'b1;
      end
      if (b <= STR_SHORT_MAX) begin
        n = 32'(b - STR_BASE);
        if (n == 0) begin
          if (last) st_phase = PH_HDR;
          r.kind = K_EMPTY;
          return 1'b1;
        end
        st_pay_left = CNT_W'(n);
        st_first    = 1'b1;
        st_phase    = PH_PAY;
        if (last) return raise_err(ERR_TRUNC, last, r);
        return 1'b0;
      end
      if (b <= STR_LONG_MAX) begin
        n = 32'(b - STR_SHORT_MAX);
        if (n > LEN_BYTES) return raise_err(ERR_WIDE, last, r);
        st_len_left = n;
        st_accum    = '0;
        st_phase    = PH_SLEN;
        if (last) return raise_err(ERR_TRUNC, last, r);
        return 1'b0;
      end
      return raise_err(ERR_NESTED, last, r);
    end

    if (st_phase == PH_SLEN) begin
      st_accum = (st_accum << 8) | CNT_W'(b);
      if (st_len_left > 0) st_len_left--;
      if (st_len_left == 0) begin
        if (st_accum == '0) begin
          st_phase = last ? PH_HDR : PH_ITEM;
          r.kind   = K_EMPTY;
          return 1'b1;
        end
        st_pay_left = st_accum;
        st_first    = 1'b1;
        st_phase    = PH_PAY;
      end
      if (last) return raise_err(ERR_TRUNC, last, r);
      return 1'b0;
    end

    // string payload
    if (st_pay_left > 0) st_pay_left--;
    if (last && st_pay_left != 0) return raise_err(ERR_TRUNC, last, r);
    r.data       = b;
    r.item_start = st_first;
    r.item_end   = (st_pay_left == 0);
    st_first     = 1'b0;
    if (st_pay_left == 0) st_phase = last ? PH_HDR : PH_ITEM;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst_n) begin
      st_phase    = PH_HDR;
      st_len_left = 0;
      st_accum    = '0;
      st_pay_left = '0;
      st_declared = '0;
      st_seen     = '0;
      st_first    = 1'b0;
      decoded_q.delete();
      mismatch_cnt <= 0;
      outstanding  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_kind, out_data, out_item_start, out_item_end, out_msg_end, out_err_code};
        if (decoded_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("%0t: unexpected out_ transaction kind=%0d data=%02h err=%0d",
                     $time, got.kind, got.data, got.err_code);
          mismatch_cnt <= mismatch_cnt + 1;
        end else begin
          want = decoded_q.pop_front();
          if (got.kind !== want.kind || got.data !== want.data ||
              got.item_start !== want.item_start || got.item_end !== want.item_end ||
              got.msg_end !== want.msg_end || got.err_code !== want.err_code) begin
            if (mismatch_cnt < 10)
              $display({"%0t: out_ mismatch want kind=%0d data=%02h st=%0b en=%0b me=%0b ",
                        "err=%0d / got kind=%0d data=%02h st=%0b en=%0b me=%0b err=%0d"},
                       $time, want.kind, want.data, want.item_start, want.item_end,
                       want.msg_end, want.err_code, got.kind, got.data, got.item_start,
                       got.item_end, got.msg_end, got.err_code);
            mismatch_cnt <= mismatch_cnt + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (decode_byte(in_byte, in_last, want)) queue_result(want);
      end
      outstanding <= decoded_q.size();
    end
  end

endmodule

>>> dv/rlp_flat_list_decoder_tb.sv
`timescale 1ns / 100ps
module rlp_flat_list_decoder_tb
  import rlpd_pkg::*;
();

  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 8;
  localparam int RANDOM_BYTES = 1125;

  // {last, byte}
  localparam logic [8:0] DIRECTED [25] = '{
    9'h1c0,                          // empty list
    9'h100,                          // first byte is not a list header
    9'h0c2, 9'h000, 9'h17f,          // single-byte items at both ends
    9'h0c1, 9'h180,                  // empty string
    9'h0c2, 9'h0c0, 9'h100,          // nested list, tail dropped
    9'h1fc,                          // list length field too wide
    9'h0c2, 9'h082, 9'h1ff,          // payload cut short
    9'h0c5, 9'h101,                  // declared length runs past the message
    9'h0c1, 9'h001, 9'h102,          // trailing item past the declared length
    9'h0f8, 9'h002, 9'h0b8, 9'h100,  // long forms, zero-length string
    9'h0c1, 9'h1bf                   // string length field too wide
  };

  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte  = 8'h00;
  logic       in_last  = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_data;
  logic       out_item_start;
  logic       out_item_end;
  logic       out_msg_end;
  logic [2:0] out_err_code;
  int         mismatch_cnt;
  int         outstanding;

  int send_gap_pct = 25;
  int recv_gap_pct = 53;
  int bytes_sent   = 0;
  int quiet_cycles = 0;

  logic [7:0] body_q[$];
  logic [7:0] msg_q[$];

  rlp_flat_list_decoder dut (.*);
  rlpd_stream_check     chk (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_gap_pct);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // append one byte to the message or to the list body
  function automatic void append_byte(input bit into_msg, input logic [7:0] b);
    if (into_msg) msg_q = {msg_q, b};
    else body_q = {body_q, b};
  endfunction

  function automatic int min_len_bytes(input int unsigned v);
    int k;
    k = 1;
    while (k < LEN_BYTES && (v >> (8 * k)) != 0) k++;
    return k;
  endfunction

  // big-endian length field into the header or the body
  function automatic void put_field(input bit into_msg, input int unsigned v, input int n);
    for (int i = n - 1; i >= 0; i--) begin
      append_byte(into_msg, 8'(v >> (8 * i)));
    end
  endfunction

  function automatic void add_item();
    int unsigned len;
    int n;
    case ($urandom_range(9))
      0, 1, 2: begin
        append_byte(1'b0, 8'($urandom_range(127)));
        return;
      end
      3, 4, 5, 6: begin
        len = ($urandom_range(3) == 0) ? $urandom_range(55) : $urandom_range(6);
        append_byte(1'b0, STR_BASE + 8'(len));
      end
      default: begin
        len = ($urandom_range(15) == 0) ? $urandom_range(300, 56) : $urandom_range(60);
        n = min_len_bytes(len);
        n += $urandom_range(LEN_BYTES - n);
        append_byte(1'b0, STR_SHORT_MAX + 8'(n));
        put_field(1'b0, len, n);
      end
    endcase
    repeat (len) append_byte(1'b0, 8'($urandom));
  endfunction

  // flaw: 0..11 clean, 12 trailing items, 13 nested list, 14 wide string length,
  // 15 wide list length, 16 huge string cut off, 17 overrun, 18 cut, 19 not a list
  function automatic void build_message();
    int unsigned total;
    int n;
    int flaw;
    body_q.delete();
    msg_q.delete();
    if ($urandom_range(24) == 0) begin
      repeat ($urandom_range(8, 1)) append_byte(1'b1, 8'($urandom));
      return;
    end
    flaw = $urandom_range(19);
    repeat ($urandom_range(5)) add_item();
    if (flaw == 13) begin
      append_byte(1'b0, 8'($urandom_range(255, LIST_BASE)));
      add_item();
    end
    if (flaw == 14 && LEN_BYTES < 8) begin
      append_byte(1'b0, 8'($urandom_range(STR_LONG_MAX, STR_SHORT_MAX + LEN_BYTES + 1)));
      add_item();
    end
    if (flaw == 16) begin
      append_byte(1'b0, STR_SHORT_MAX + 8'(LEN_BYTES));
      append_byte(1'b0, 8'($urandom_range(255, 1)));
      repeat (LEN_BYTES - 1) append_byte(1'b0, 8'($urandom));
      repeat ($urandom_range(4)) append_byte(1'b0, 8'($urandom));
    end
    total = body_q.size();
    if (flaw == 12) repeat ($urandom_range(3, 1)) add_item();
    if (flaw == 17)
      total = ($urandom_range(1) == 1) ? total + $urandom_range(20, 1) : ($urandom | 32'h100);

    if (flaw == 15 && LEN_BYTES < 8) begin
      append_byte(1'b1, 8'($urandom_range(255, LIST_SHORT_MAX + LEN_BYTES + 1)));
    end else if (total <= 55 && $urandom_range(1) == 1) begin
      append_byte(1'b1, LIST_BASE + 8'(total));
    end else begin
      n = min_len_bytes(total);
      n += $urandom_range(LEN_BYTES - n);
      append_byte(1'b1, LIST_SHORT_MAX + 8'(n));
      put_field(1'b1, total, n);
    end
    foreach (body_q[i]) append_byte(1'b1, body_q[i]);

    if (flaw == 18 && msg_q.size() > 1)
      repeat ($urandom_range(msg_q.size() - 1, 1)) void'(msg_q.pop_back());
    if (flaw == 19) msg_q[0] = 8'($urandom_range(LIST_BASE - 1));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // hold off the sender until every pending transaction has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic send_message();
    foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1);
    if ($urandom_range(39) == 0) drain();
  endtask

  initial begin
    int target;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_gap_pct = 53;
        recv_gap_pct = 25;
      end else if (ph == 2) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      target = $size(DIRECTED) + (ph + 1) * RANDOM_BYTES / 3;
      while (bytes_sent < target) begin
        build_message();
        send_message();
      end
      drain();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && outstanding == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/rlpd_pkg.sv
hw/rtl/rlpd_decode.sv
hw/rtl/rlp_flat_list_decoder.sv
dv/rlpd_stream_check.sv
dv/rlp_flat_list_decoder_tb.sv
